[hw/rtl/lru_key_value_cache_top_defines.svh]
// Assertion macros used by the checker file of the cache.
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LKV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lkv assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lkv assertion failed");

`endif

[hw/rtl/lkv_pkg.sv]
`timescale 1ns / 1ps
package lkv_pkg;

	localparam int DEF_MAX_ENTRIES = 16;
	localparam int CFG_W = 5;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;
	localparam logic [VAL_W-1:0] MISS_DATA = 32'hFFFF_FFFF;

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_SET = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_FIN,
		ST_UPD,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic key_eq;
		logic rank_gt;
		logic rank_lt;
	} cmp_res_t;

endpackage

[hw/rtl/lkv_ram.sv]
`timescale 1ns / 1ps
module lkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/lkv_cmp.sv]
`timescale 1ns / 1ps
module lkv_cmp import lkv_pkg::*; #(
	parameter int RANK_W = 4
) (
	input  logic [KEY_W-1:0]  key_a,
	input  logic [KEY_W-1:0]  key_b,
	input  logic [RANK_W-1:0] rank_a,
	input  logic [RANK_W-1:0] rank_b,
	output cmp_res_t          res,
	output logic [RANK_W-1:0] rank_inc
);

	// One comparator serves the lookup scan and the recency update scan.
	always_comb begin
		res.key_eq  = (key_a == key_b);
		res.rank_gt = (rank_a > rank_b);
		res.rank_lt = (rank_a < rank_b);
		rank_inc    = rank_a + RANK_W'(1);
	end

endmodule

[hw/rtl/lru_key_value_cache_top.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid / cfg_ready  cfg_data (capacity)
// in        in         in_valid / in_ready    action, key, value
// out       out        out_valid / out_ready  hit, data
//
// A get or a set keeps the input side busy until it is done: one comparator
// walks the entry memories one entry per cycle, once to look up and once
// more on a set to age the ranks.
// A get whose result cannot leave because the output register is full waits
// until out_ready. Reset clears the valid bits at once; there is no clearing
// pass. cfg_ready is always high.
module lru_key_value_cache_top import lkv_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    action,
	input  logic signed [KEY_W-1:0] key,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    hit,
	output logic signed [VAL_W-1:0] data
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CAP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
	localparam logic [CAP_W-1:0] MAX_CAP = CAP_W'(MAX_ENTRIES);

	state_t state_q, state_d;

	logic [CFG_W-1:0]       cap_q;
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [MAX_ENTRIES-1:0] valid_d;
	logic [CNT_W-1:0]       count_q;

	logic             action_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;

	logic [IDX_W-1:0] cnt_q;
	logic             scan_act_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             found_q;
	logic [IDX_W-1:0] slot_q;
	logic [IDX_W-1:0] old_q;
	logic [VAL_W-1:0] data_q;
	logic             vic_found_q;
	logic [IDX_W-1:0] vic_q;
	logic [IDX_W-1:0] best_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_q;
	logic             miss_q;

	logic             out_valid_q;
	logic             hit_q;
	logic [VAL_W-1:0] out_data_q;

	logic [KEY_W-1:0] key_rd;
	logic [VAL_W-1:0] value_rd;
	logic [IDX_W-1:0] rank_rd;

	cmp_res_t         cmp_res;
	logic [IDX_W-1:0] rank_inc;
	logic [IDX_W-1:0] rank_ref;

	logic             accept;
	logic             scan_last;
	logic             start_upd;
	logic             fin_set;
	logic             load_out;
	logic [CAP_W-1:0] eff_cap;
	logic             evict;
	logic [IDX_W-1:0] new_slot;
	logic [IDX_W-1:0] ins_slot;
	logic             entry_v_s1;
	logic             rank_we;
	logic [IDX_W-1:0] rank_new;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign data      = out_data_q;

	assign scan_last  = vld_s1 && (idx_s1 == LAST_IDX);
	assign fin_set    = (state_q == ST_FIN) && (action_q == ACT_SET);
	assign start_upd  = fin_set;
	assign entry_v_s1 = valid_q[idx_s1];

	// Capacity zero acts as one, and anything above MAX_ENTRIES saturates.
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CAP_W'(1);
		end else if (CAP_W'(cap_q) > MAX_CAP) begin
			eff_cap = MAX_CAP;
		end else begin
			eff_cap = CAP_W'(cap_q);
		end
	end

	// A new key takes the lowest free slot, and the slot freed by eviction
	// counts as free.
	always_comb begin
		evict = !found_q && (CAP_W'(count_q) >= eff_cap);
		if (evict && (!free_found_q || (vic_q < free_q))) begin
			new_slot = vic_q;
		end else begin
			new_slot = free_q;
		end
		ins_slot = found_q ? slot_q : new_slot;
	end

	always_comb begin
		valid_d = valid_q;
		if (evict) begin
			valid_d[vic_q] = 1'b0;
		end
		valid_d[ins_slot] = 1'b1;
	end

	assign rank_ref = (state_q == ST_UPD) ? old_q : best_q;

	lkv_cmp #(
		.RANK_W(IDX_W)
	) u_cmp (
		.key_a   (key_rd),
		.key_b   (key_q),
		.rank_a  (rank_rd),
		.rank_b  (rank_ref),
		.res     (cmp_res),
		.rank_inc(rank_inc)
	);

	// On a miss every valid entry ages; on a hit only those younger than it.
	always_comb begin
		rank_we = (state_q == ST_UPD) && vld_s1;
		if (idx_s1 == slot_q) begin
			rank_new = '0;
		end else if (entry_v_s1 && (miss_q || cmp_res.rank_lt)) begin
			rank_new = rank_inc;
		end else begin
			rank_new = rank_rd;
		end
	end

	lkv_ram #(
		.WIDTH(KEY_W),
		.DEPTH(MAX_ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (fin_set && !found_q),
		.waddr(ins_slot),
		.wdata(key_q),
		.raddr(cnt_q),
		.rdata(key_rd)
	);

	lkv_ram #(
		.WIDTH(VAL_W),
		.DEPTH(MAX_ENTRIES)
	) u_value_ram (
		.clk  (clk),
		.we   (fin_set),
		.waddr(ins_slot),
		.wdata(value_q),
		.raddr(cnt_q),
		.rdata(value_rd)
	);

	lkv_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_ENTRIES)
	) u_rank_ram (
		.clk  (clk),
		.we   (rank_we),
		.waddr(idx_s1),
		.wdata(rank_new),
		.raddr(cnt_q),
		.rdata(rank_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (scan_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = (action_q == ACT_SET) ? ST_UPD : ST_RESP;
			end
			ST_UPD: begin
				if (scan_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= CAP_RESET;
			valid_q      <= '0;
			count_q      <= '0;
			cnt_q        <= '0;
			scan_act_q   <= 1'b0;
			vld_s1       <= 1'b0;
			found_q      <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			miss_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end

			// Read addresses run ahead of the data stage, which sees each in the cycle after.
			if (accept || start_upd) begin
				cnt_q      <= '0;
				scan_act_q <= 1'b1;
			end else if (scan_act_q) begin
				if (cnt_q == LAST_IDX) begin
					scan_act_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + IDX_W'(1);
				end
			end
			vld_s1 <= scan_act_q;

			if (accept) begin
				found_q      <= 1'b0;
				vic_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end else if ((state_q == ST_LOOK) && vld_s1) begin
				if (entry_v_s1 && cmp_res.key_eq) begin
					found_q <= 1'b1;
				end
				if (entry_v_s1 && (!vic_found_q || cmp_res.rank_gt)) begin
					vic_found_q <= 1'b1;
				end
				if (!entry_v_s1) begin
					free_found_q <= 1'b1;
				end
			end

			if (fin_set) begin
				miss_q <= !found_q;
				if (!found_q) begin
					valid_q <= valid_d;
					count_q <= CNT_W'(count_q + CNT_W'(1) - CNT_W'(evict));
				end
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			key_q    <= key;
			value_q  <= value;
		end

		if ((state_q == ST_LOOK) && vld_s1) begin
			if (entry_v_s1 && cmp_res.key_eq) begin
				slot_q <= idx_s1;
				old_q  <= rank_rd;
				data_q <= value_rd;
			end
			if (entry_v_s1 && (!vic_found_q || cmp_res.rank_gt)) begin
				vic_q  <= idx_s1;
				best_q <= rank_rd;
			end
			if (!entry_v_s1 && !free_found_q) begin
				free_q <= idx_s1;
			end
		end

		if (fin_set) begin
			slot_q <= ins_slot;
		end

		idx_s1 <= cnt_q;

		if (load_out) begin
			hit_q      <= found_q;
			out_data_q <= found_q ? data_q : MISS_DATA;
		end
	end

endmodule

[hw/rtl/lkv_checker.sv]
`timescale 1ns / 1ps
`include "lru_key_value_cache_top_defines.svh"
module lkv_checker import lkv_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    action,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic                    hit,
	input logic signed [VAL_W-1:0] data
);

	// Once an item is taken the block scans its entries and cannot take another.
	`LKV_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// A set never produces a result item.
	`LKV_ASSERT_NEXT(a_set_silent, clk, arst_n,
		in_valid && in_ready && (action == ACT_SET) && !out_valid, !out_valid)

	// A miss always reports all ones.
	`LKV_ASSERT_NOW(a_miss_data, clk, arst_n, out_valid && !hit, data == MISS_DATA)

	// A result held back by the consumer stays put.
	`LKV_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(hit) && $stable(data))

endmodule

bind lru_key_value_cache_top lkv_checker u_lkv_checker (.*);
